// File: hdl/loop_sequencer_position_counter_macros.svh
// Assertion macros for the loop sequencer position counter.
// Used by the top level; depends on nothing else.
`ifndef LOOP_SEQUENCER_POSITION_COUNTER_MACROS_SVH
`define LOOP_SEQUENCER_POSITION_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lspc_pkg.sv
// Shared types and codes for the loop sequencer position counter.
// No dependencies.
package lspc_pkg;

    // Command codes carried on the input mode field.
    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_REC_START = 3'd1,
        MODE_REC_STOP  = 3'd2,
        MODE_RESET     = 3'd3,
        MODE_SET_LEN   = 3'd4
    } mode_t;

    localparam int MODE_W  = 3;
    localparam int STEPS_W = 6;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STEPS_W-1:0] steps;
        logic               has_events;
    } cmd_t;

    typedef struct packed {
        logic        adaptive;
        logic        recording;
        logic [5:0]  loop_steps;
        logic [4:0]  previous_step;
        logic [11:0] previous_position;
        logic [7:0]  pulse_in_step;
        logic [4:0]  step_index;
        logic [11:0] position;
    } result_t;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;

endpackage

// File: hdl/lspc_step.sv
// Next-state logic of the position counter for one command.
// Depends on lspc_pkg.
module lspc_step #(
    parameter int PULSES_PER_STEP   = 96,
    parameter int MAX_STEPS         = 32,
    parameter int BLOCK_ONE_STEPS   = 8,
    parameter int BLOCK_TWO_STEPS   = 16,
    parameter int BLOCK_THREE_STEPS = 24,
    parameter int BLOCK_FOUR_STEPS  = 32,
    parameter int POS_W             = $clog2(MAX_STEPS * PULSES_PER_STEP),
    parameter int STEP_W            = $clog2(MAX_STEPS),
    parameter int PH_W              = $clog2(PULSES_PER_STEP),
    parameter int LEN_W             = $clog2(MAX_STEPS + 1)
) (
    input  lspc_pkg::cmd_t    cmd,
    input  logic [POS_W-1:0]  pos,
    input  logic [STEP_W-1:0] step,
    input  logic [PH_W-1:0]   phase,
    input  logic [7:0]        cnt,
    input  logic [11:0]       last_pos,
    input  logic [4:0]        last_step,
    input  logic [LEN_W-1:0]  len,
    input  logic              rec,
    input  logic              adp,
    output logic [POS_W-1:0]  pos_next,
    output logic [STEP_W-1:0] step_next,
    output logic [PH_W-1:0]   phase_next,
    output logic [7:0]        cnt_next,
    output logic [11:0]       last_pos_next,
    output logic [4:0]        last_step_next,
    output logic [LEN_W-1:0]  len_next,
    output logic              rec_next,
    output logic              adp_next,
    output lspc_pkg::result_t res
);
    import lspc_pkg::*;

    localparam int LP_W          = POS_W + 1;
    localparam int PULSE_SAT_RAW = 2 * PULSES_PER_STEP - 1;
    localparam logic [7:0] PULSE_SAT = 8'((PULSE_SAT_RAW > 255) ? 255 : PULSE_SAT_RAW);

    logic [LP_W-1:0]   pos_inc;
    logic [LP_W-1:0]   loop_pulses;
    logic [STEP_W:0]   step_tmp;
    logic              boundary;
    int                block;

    assign pos_inc     = LP_W'(pos) + LP_W'(1);
    assign loop_pulses = LP_W'(len) * LP_W'(PULSES_PER_STEP);
    assign boundary    = (phase == PH_W'(PULSES_PER_STEP - 1));
    assign step_tmp    = (STEP_W + 1)'(step) + (STEP_W + 1)'(boundary);

    // round-up block for stop recording
    always_comb
    begin
        if (step <= STEP_W'(0) + BLOCK_ONE_STEPS)
            block = BLOCK_ONE_STEPS;
        else if (step <= BLOCK_TWO_STEPS)
            block = BLOCK_TWO_STEPS;
        else if (step <= BLOCK_THREE_STEPS)
            block = BLOCK_THREE_STEPS;
        else
            block = BLOCK_FOUR_STEPS;
    end

    always_comb
    begin
        pos_next       = pos;
        step_next      = step;
        phase_next     = phase;
        cnt_next       = cnt;
        last_pos_next  = last_pos;
        last_step_next = last_step;
        len_next       = len;
        rec_next       = rec;
        adp_next       = adp;

        case (cmd.mode)
            MODE_TICK:
            begin
                last_pos_next = 12'(pos);
                if (cnt < PULSE_SAT)
                    cnt_next = cnt + 8'd1;
                if (boundary)
                begin
                    last_step_next = 5'(step);
                    cnt_next       = 8'd0;
                    phase_next     = '0;
                end
                else
                begin
                    phase_next = phase + PH_W'(1);
                end
                pos_next  = POS_W'(pos_inc);
                step_next = STEP_W'(step_tmp);
                if (pos_inc >= loop_pulses)
                begin
                    if (rec && adp)
                    begin
                        // keep counting until the full length is reached
                        if (step_tmp >= (STEP_W + 1)'(MAX_STEPS))
                        begin
                            adp_next   = 1'b0;
                            len_next   = LEN_W'(MAX_STEPS);
                            pos_next   = '0;
                            step_next  = '0;
                            phase_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next   = '0;
                        step_next  = '0;
                        phase_next = '0;
                    end
                end
            end
            MODE_REC_START:
            begin
                rec_next = 1'b1;
                if (!cmd.has_events)
                begin
                    last_pos_next  = 12'(pos);
                    last_step_next = 5'(step);
                    pos_next       = '0;
                    step_next      = '0;
                    phase_next     = '0;
                    len_next       = LEN_W'(2);
                    adp_next       = 1'b1;
                end
                else
                begin
                    adp_next = 1'b0;
                end
            end
            MODE_REC_STOP:
            begin
                rec_next = 1'b0;
                if (adp)
                begin
                    adp_next = 1'b0;
                    if (cmd.has_events && block > 0 && block <= MAX_STEPS)
                        len_next = LEN_W'(block);
                end
            end
            MODE_RESET:
            begin
                last_pos_next  = 12'(pos);
                last_step_next = 5'(step);
                pos_next       = '0;
                step_next      = '0;
                phase_next     = '0;
            end
            MODE_SET_LEN:
            begin
                if (cmd.steps != '0 && 32'(cmd.steps) <= MAX_STEPS)
                    len_next = LEN_W'(cmd.steps);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.position          = 12'(pos_next);
        res.step_index        = 5'(step_next);
        res.pulse_in_step     = cnt_next;
        res.previous_position = last_pos_next;
        res.previous_step     = last_step_next;
        res.loop_steps        = 6'(len_next);
        res.recording         = rec_next;
        res.adaptive          = adp_next;
    end

endmodule

// File: hdl/loop_sequencer_position_counter.sv
// Loop sequencer position counter: input register, next-state logic, result register.
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle while m_tready is high; lspc_step computes the next
// state combinationally, with the state registers fed back directly.
// Reset (rst_n low, asynchronous): both stages empty, counters zero, length MAX_STEPS.
// Depends on lspc_pkg, lspc_step and loop_sequencer_position_counter_macros.svh.
`include "loop_sequencer_position_counter_macros.svh"

module loop_sequencer_position_counter #(
    parameter int PULSES_PER_STEP   = 96,
    parameter int MAX_STEPS         = 32,
    parameter int BLOCK_ONE_STEPS   = 8,
    parameter int BLOCK_TWO_STEPS   = 16,
    parameter int BLOCK_THREE_STEPS = 24,
    parameter int BLOCK_FOUR_STEPS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] steps, [6] has_events, [7] zero
    input  logic [lspc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [2:0] mode
    input  logic [lspc_pkg::MODE_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] position, [16:12] step_index, [24:17] pulse_in_step,
    // [36:25] previous_position, [41:37] previous_step, [47:42] loop_steps,
    // [48] recording, [49] adaptive, [55:50] zero
    output logic [lspc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import lspc_pkg::*;

    localparam int POS_W  = $clog2(MAX_STEPS * PULSES_PER_STEP);
    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int PH_W   = $clog2(PULSES_PER_STEP);
    localparam int LEN_W  = $clog2(MAX_STEPS + 1);

    // input stage
    logic              in_valid_reg;
    cmd_t              cmd_reg;

    // result stage
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    // counter state; phase tracks position modulo one step
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [STEP_W-1:0] step_reg,      step_next;
    logic [PH_W-1:0]   phase_reg,     phase_next;
    logic [7:0]        cnt_reg,       cnt_next;
    logic [11:0]       last_pos_reg,  last_pos_next;
    logic [4:0]        last_step_reg, last_step_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic              rec_reg,       rec_next;
    logic              adp_reg,       adp_next;

    logic              advance;
    logic              in_accept;

    // An item moves on when the result register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_DATA_W'(res_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg.mode       <= s_tuser;
            cmd_reg.steps      <= s_tdata[STEPS_W-1:0];
            cmd_reg.has_events <= s_tdata[STEPS_W];
        end
    end

    lspc_step #(
        .PULSES_PER_STEP   (PULSES_PER_STEP),
        .MAX_STEPS         (MAX_STEPS),
        .BLOCK_ONE_STEPS   (BLOCK_ONE_STEPS),
        .BLOCK_TWO_STEPS   (BLOCK_TWO_STEPS),
        .BLOCK_THREE_STEPS (BLOCK_THREE_STEPS),
        .BLOCK_FOUR_STEPS  (BLOCK_FOUR_STEPS),
        .POS_W             (POS_W),
        .STEP_W            (STEP_W),
        .PH_W              (PH_W),
        .LEN_W             (LEN_W)
    ) u_step (
        .cmd            (cmd_reg),
        .pos            (pos_reg),
        .step           (step_reg),
        .phase          (phase_reg),
        .cnt            (cnt_reg),
        .last_pos       (last_pos_reg),
        .last_step      (last_step_reg),
        .len            (len_reg),
        .rec            (rec_reg),
        .adp            (adp_reg),
        .pos_next       (pos_next),
        .step_next      (step_next),
        .phase_next     (phase_next),
        .cnt_next       (cnt_next),
        .last_pos_next  (last_pos_next),
        .last_step_next (last_step_next),
        .len_next       (len_next),
        .rec_next       (rec_next),
        .adp_next       (adp_next),
        .res            (res_next)
    );

    // State commits together with the result it produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            step_reg      <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            last_pos_reg  <= '0;
            last_step_reg <= '0;
            len_reg       <= LEN_W'(MAX_STEPS);
            rec_reg       <= 1'b0;
            adp_reg       <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            last_pos_reg  <= last_pos_next;
            last_step_reg <= last_step_next;
            len_reg       <= len_next;
            rec_reg       <= rec_next;
            adp_reg       <= adp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // Position, step and phase must stay consistent.
    `LSPC_ASSERT_NOW(a_pos_consistent, clk, rst_n, 1'b1,
        (POS_W + 8)'(step_reg) * (POS_W + 8)'(PULSES_PER_STEP) + (POS_W + 8)'(phase_reg)
            == (POS_W + 8)'(pos_reg),
        "position, step and phase out of step")
    // Adaptive counting only runs while recording.
    `LSPC_ASSERT_NOW(a_adaptive_rec, clk, rst_n, adp_reg, rec_reg,
        "adaptive mode without recording")
    // Loop length stays in range.
    `LSPC_ASSERT_NOW(a_len_range, clk, rst_n, 1'b1,
        len_reg != '0 && 32'(len_reg) <= MAX_STEPS, "loop length out of range")
    // An item that advances always shows up as a result next cycle.
    `LSPC_ASSERT_NEXT(a_adv_out, clk, rst_n, advance, m_tvalid,
        "advanced item produced no result")

endmodule
